>>> hw/rtl/mrx_pkg.sv
// Package for the MQTT receive deframer: result record and queue entry
// types, keep limits and result kind codes. No dependencies.
package mrx_pkg;

  localparam logic [15:0] TOPIC_KEEP   = 16'd64;
  localparam logic [15:0] PAYLOAD_KEEP = 16'd255;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] KIND_TOPIC = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [3:0]  packet_type;
    logic [1:0]  qos_level;
    logic [15:0] packet_id;
    logic [6:0]  topic_length;
    logic [7:0]  payload_length;
    logic        truncated;
    logic        malformed;
    logic        last;
  } res_t;

  // One queue entry holds every result of one input byte.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } q_entry_t;

endpackage

>>> hw/rtl/mrx_front.sv
// Front end of the MQTT receive deframer: parses the byte stream and builds
// the results of each byte as one queue entry. Depends on mrx_pkg.
module mrx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output mrx_pkg::q_entry_t push_ent
);

  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_LEN   = 4'd1;
  localparam logic [3:0] PH_TLH   = 4'd2;
  localparam logic [3:0] PH_TLL   = 4'd3;
  localparam logic [3:0] PH_TOPIC = 4'd4;
  localparam logic [3:0] PH_IDH   = 4'd5;
  localparam logic [3:0] PH_IDL   = 4'd6;
  localparam logic [3:0] PH_PAY   = 4'd7;
  localparam logic [3:0] PH_SKIP  = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [27:0] rl_r, rl_nxt;
  logic [1:0]  lbc_r, lbc_nxt;
  logic [27:0] cons_r, cons_nxt;
  logic [15:0] tt_r, tt_nxt;
  logic [27:0] fc_r, fc_nxt;
  logic [15:0] id_r, id_nxt;
  logic        tr_r, tr_nxt;

  logic        in_body, done, publish;
  logic [1:0]  qos;
  logic [27:0] cons_inc, fc_inc, len_part;
  logic [17:0] need;
  logic        e_first, e_end;
  logic [1:0]  f_kind;
  logic [15:0] f_idx;
  logic [6:0]  e_tl;
  logic [7:0]  e_pl;
  logic        e_mal, use_tk, use_pk;
  logic [15:0] tk16;
  logic [27:0] pk28;
  mrx_pkg::res_t base, first_rec, end_rec;

  assign publish = (hdr_r[7:4] == 4'h3);
  assign qos     = publish ? hdr_r[2:1] : 2'd0;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    rl_nxt    = rl_r;
    lbc_nxt   = lbc_r;
    cons_nxt  = cons_r;
    tt_nxt    = tt_r;
    fc_nxt    = fc_r;
    id_nxt    = id_r;
    tr_nxt    = tr_r;
    e_first   = 1'b0;
    e_end     = 1'b0;
    f_kind    = mrx_pkg::KIND_TOPIC;
    f_idx     = 16'd0;
    e_mal     = 1'b0;
    use_tk    = 1'b0;
    use_pk    = 1'b0;
    need      = 18'd0;
    len_part  = 28'd0;
    cons_inc  = cons_r + 28'd1;
    fc_inc    = fc_r + 28'd1;
    in_body   = (phase_r >= PH_TLH) && (phase_r <= PH_SKIP);
    done      = in_body && (cons_inc >= rl_r);
    if (acc) begin
      if (in_body) begin
        cons_nxt = cons_inc;
      end
      unique case (phase_r)
        PH_HDR: begin
          hdr_nxt   = rx_byte;
          rl_nxt    = 28'd0;
          lbc_nxt   = 2'd0;
          cons_nxt  = 28'd0;
          tt_nxt    = 16'd0;
          fc_nxt    = 28'd0;
          id_nxt    = 16'd0;
          tr_nxt    = 1'b0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          case (lbc_r)
            2'd0:    len_part = {21'd0, rx_byte[6:0]};
            2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
            default: len_part = {rx_byte[6:0], 21'd0};
          endcase
          rl_nxt = rl_r | len_part;
          if (rx_byte[7]) begin
            if (lbc_r == 2'd3) begin
              e_end     = 1'b1;
              e_mal     = 1'b1;
              phase_nxt = PH_HDR;
            end else begin
              lbc_nxt = lbc_r + 2'd1;
            end
          end else if (publish) begin
            if (rl_nxt < 28'd2) begin
              e_end     = 1'b1;
              e_mal     = 1'b1;
              phase_nxt = (rl_nxt == 28'd0) ? PH_HDR : PH_SKIP;
            end else begin
              phase_nxt = PH_TLH;
            end
          end else begin
            phase_nxt = (rl_nxt == 28'd0) ? PH_HDR : PH_SKIP;
          end
        end
        PH_TLH: begin
          tt_nxt    = {rx_byte, 8'd0};
          phase_nxt = PH_TLL;
        end
        PH_TLL: begin
          tt_nxt = {tt_r[15:8], rx_byte};
          need   = 18'd2 + {2'd0, tt_nxt} + ((qos != 2'd0) ? 18'd2 : 18'd0);
          if ({10'd0, need} > rl_r) begin
            e_end     = 1'b1;
            e_mal     = 1'b1;
            phase_nxt = done ? PH_HDR : PH_SKIP;
          end else if (tt_nxt != 16'd0) begin
            fc_nxt    = 28'd0;
            phase_nxt = PH_TOPIC;
          end else if (qos != 2'd0) begin
            phase_nxt = PH_IDH;
          end else if (done) begin
            e_end     = 1'b1;
            use_tk    = 1'b1;
            phase_nxt = PH_HDR;
          end else begin
            fc_nxt    = 28'd0;
            phase_nxt = PH_PAY;
          end
        end
        PH_TOPIC: begin
          if (fc_r < {12'd0, mrx_pkg::TOPIC_KEEP}) begin
            e_first = 1'b1;
            f_kind  = mrx_pkg::KIND_TOPIC;
            f_idx   = fc_r[15:0];
          end else begin
            tr_nxt = 1'b1;
          end
          fc_nxt = fc_inc;
          if (fc_inc >= {12'd0, tt_r}) begin
            if (qos != 2'd0) begin
              phase_nxt = PH_IDH;
            end else if (done) begin
              e_end     = 1'b1;
              use_tk    = 1'b1;
              phase_nxt = PH_HDR;
            end else begin
              fc_nxt    = 28'd0;
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_IDH: begin
          id_nxt    = {rx_byte, 8'd0};
          phase_nxt = PH_IDL;
        end
        PH_IDL: begin
          id_nxt = {id_r[15:8], rx_byte};
          if (qos == 2'd1) begin
            e_first = 1'b1;
            f_kind  = mrx_pkg::KIND_ACK;
          end
          if (done) begin
            e_end     = 1'b1;
            use_tk    = 1'b1;
            phase_nxt = PH_HDR;
          end else begin
            fc_nxt    = 28'd0;
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          if (fc_r < {12'd0, mrx_pkg::PAYLOAD_KEEP}) begin
            e_first = 1'b1;
            f_kind  = mrx_pkg::KIND_PAY;
            f_idx   = fc_r[15:0];
          end else begin
            tr_nxt = 1'b1;
          end
          fc_nxt = fc_inc;
          if (done) begin
            e_end     = 1'b1;
            use_tk    = 1'b1;
            use_pk    = 1'b1;
            phase_nxt = PH_HDR;
          end
        end
        PH_SKIP: begin
          if (done) begin
            phase_nxt = PH_HDR;
          end
        end
        default: begin
          phase_nxt = PH_HDR;
        end
      endcase
    end
  end

  // kept lengths, saturated to the field widths
  always_comb begin
    tk16 = (tt_nxt < mrx_pkg::TOPIC_KEEP) ? tt_nxt : mrx_pkg::TOPIC_KEEP;
    pk28 = (fc_nxt < {12'd0, mrx_pkg::PAYLOAD_KEEP}) ? fc_nxt
                                                   : {12'd0, mrx_pkg::PAYLOAD_KEEP};
    e_tl = 7'd0;
    e_pl = 8'd0;
    if (use_tk) begin
      e_tl = (tk16 > 16'd127) ? 7'd127 : tk16[6:0];
    end
    if (use_pk) begin
      e_pl = (pk28 > 28'd255) ? 8'd255 : pk28[7:0];
    end
  end

  always_comb begin
    base                = '0;
    base.packet_type    = hdr_r[7:4];
    base.qos_level      = qos;
    base.packet_id      = id_nxt;
    first_rec           = base;
    first_rec.kind      = f_kind;
    first_rec.data_byte = (f_kind == mrx_pkg::KIND_ACK) ? 8'd0 : rx_byte;
    first_rec.byte_index = f_idx;
    first_rec.last      = !e_end;
    end_rec                = base;
    end_rec.kind           = mrx_pkg::KIND_END;
    end_rec.topic_length   = e_tl;
    end_rec.payload_length = e_pl;
    end_rec.truncated      = tr_nxt;
    end_rec.malformed      = e_mal;
    end_rec.last           = 1'b1;
  end

  assign push         = acc && (e_first || e_end);
  assign push_ent.two = e_first && e_end;
  assign push_ent.r0  = e_first ? first_rec : end_rec;
  assign push_ent.r1  = end_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hdr_r   <= 8'd0;
      rl_r    <= 28'd0;
      lbc_r   <= 2'd0;
      cons_r  <= 28'd0;
      tt_r    <= 16'd0;
      fc_r    <= 28'd0;
      id_r    <= 16'd0;
      tr_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      rl_r    <= rl_nxt;
      lbc_r   <= lbc_nxt;
      cons_r  <= cons_nxt;
      tt_r    <= tt_nxt;
      fc_r    <= fc_nxt;
      id_r    <= id_nxt;
      tr_r    <= tr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_two_then_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_ent.two) |-> (push_ent.r0.kind != mrx_pkg::KIND_END &&
                                push_ent.r1.kind == mrx_pkg::KIND_END))
    else $error("two-result entry not closed by packet end");
`endif

endmodule

>>> hw/rtl/mrx_queue.sv
// Result queue between parser front end and output stage of the MQTT
// receive deframer. Holds one entry per input byte that has results. Depends on mrx_pkg.
module mrx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrx_pkg::q_entry_t push_ent,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output mrx_pkg::q_entry_t head
);

  mrx_pkg::q_entry_t           ent_r [mrx_pkg::QDEPTH];
  logic [mrx_pkg::QPTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [mrx_pkg::QPTR_W:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == (mrx_pkg::QPTR_W + 1)'(mrx_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

>>> hw/rtl/mrx_back.sv
// Output stage of the MQTT receive deframer: unpacks queue entries into
// single results held in an output register. Depends on mrx_pkg.
module mrx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  mrx_pkg::q_entry_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mrx_pkg::res_t     out_rec
);

  logic          sel_r, sel_nxt;
  logic          vld_r, vld_nxt;
  logic          load;
  mrx_pkg::res_t rec_r, rec;

  assign load = !empty && (!vld_r || out_ready);
  assign rec  = sel_r ? head.r1 : head.r0;
  assign pop  = load && (sel_r || !head.two);

  always_comb begin
    sel_nxt = load ? !pop : sel_r;
    vld_nxt = load || (vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_rec   = rec_r;

`ifndef NO_ASSERTIONS
  a_second_half_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!empty && head.two))
    else $error("second result selected without a two-result head");
`endif

endmodule

>>> hw/rtl/mqtt_rx_packet_deframer.sv
// MQTT receive deframer, top level: byte input channel, result channel.
// Depends on mrx_pkg, mrx_front, mrx_queue and mrx_back.
//
// Usage:
//   Input: one received byte per transaction on in_valid/in_ready/in_rx_byte.
//   Output: one result per transaction on out_valid/out_ready and the out_*
//   fields: topic byte, payload byte, ack request or packet end. out_last
//   marks the final result caused by one input byte.
//   A byte is parsed in the cycle it is accepted; its results enter a
//   four-entry queue at that edge and then move into the output register
//   when it is empty or its result is taken. Throughput: one byte per cycle
//   while the queue is not full. The output register issues one result per
//   cycle while out_ready is high; a byte that causes two results (topic,
//   payload or ack plus packet end) holds its entry until both are loaded.
//   When the receiver stalls, the output register holds its result and the
//   queue keeps taking bytes until it is full; in_ready then drops.
//   Reset (rst_n low, synchronous) empties queue and output register and
//   returns the parser to waiting for a fixed-header byte.
module mqtt_rx_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [3:0]  out_packet_type,
  output logic [1:0]  out_qos_level,
  output logic [15:0] out_packet_id,
  output logic [6:0]  out_topic_length,
  output logic [7:0]  out_payload_length,
  output logic        out_truncated,
  output logic        out_malformed,
  output logic        out_last
);

  logic              acc, push, pop, full, empty;
  mrx_pkg::q_entry_t push_ent, head;
  mrx_pkg::res_t     rec;

  assign in_ready = !full;
  assign acc      = in_valid && !full;

  mrx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_ent (push_ent)
  );

  mrx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  mrx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (rec)
  );

  assign out_kind           = rec.kind;
  assign out_data_byte      = rec.data_byte;
  assign out_byte_index     = rec.byte_index;
  assign out_packet_type    = rec.packet_type;
  assign out_qos_level      = rec.qos_level;
  assign out_packet_id      = rec.packet_id;
  assign out_topic_length   = rec.topic_length;
  assign out_payload_length = rec.payload_length;
  assign out_truncated      = rec.truncated;
  assign out_malformed      = rec.malformed;
  assign out_last           = rec.last;

endmodule

>>> bench/testbench.sv
// Testbench for mqtt_rx_packet_deframer: drives a received byte stream and checks
// every result against a byte-by-byte deframer predictor kept in this file.
// Depends on mrx_pkg and the deframer RTL.
module testbench;

  localparam logic [3:0] PKT_PUBLISH  = 4'h3;
  localparam logic [3:0] PKT_PINGRESP = 4'hD;
  localparam int ITEM_TARGET  = 1450;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [3:0] {
    P_HEADER, P_LENGTH, P_TLEN_HI, P_TLEN_LO, P_TOPIC, P_ID_HI, P_ID_LO, P_PAYLOAD, P_SKIP
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_index;
  logic [3:0]  out_packet_type;
  logic [1:0]  out_qos_level;
  logic [15:0] out_packet_id;
  logic [6:0]  out_topic_length;
  logic [7:0]  out_payload_length;
  logic        out_truncated;
  logic        out_malformed;
  logic        out_last;

  mqtt_rx_packet_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_packet_type    (out_packet_type),
    .out_qos_level      (out_qos_level),
    .out_packet_id      (out_packet_id),
    .out_topic_length   (out_topic_length),
    .out_payload_length (out_payload_length),
    .out_truncated      (out_truncated),
    .out_malformed      (out_malformed),
    .out_last           (out_last)
  );

  // deframer state mirror
  parse_phase_t ph = P_HEADER;
  logic [7:0]   hdr_byte = 8'h00;
  logic [27:0]  rem_len = '0;
  logic [1:0]   len_cnt = '0;
  logic [27:0]  consumed = '0;
  logic [15:0]  topic_tot = '0;
  logic [27:0]  fcount = '0;
  logic [15:0]  ident = '0;
  logic         trunc = 1'b0;

  mrx_pkg::res_t step_results[$];
  mrx_pkg::res_t results_due[$];
  logic [7:0]    pkt_bytes[$];

  int   mismatches = 0;
  int   counted_items = 0;
  int   cycle_count = 0;
  logic send_gaps_on = 1'b0;
  logic recv_stalls_on = 1'b0;
  logic hold_pending = 1'b0;

  initial forever #4 clk = ~clk;

  function automatic logic [1:0] cur_qos();
    return (hdr_byte[7:4] == PKT_PUBLISH) ? hdr_byte[2:1] : 2'd0;
  endfunction

  function automatic logic [6:0] topic_kept();
    return (topic_tot < mrx_pkg::TOPIC_KEEP) ? 7'(topic_tot) : 7'(mrx_pkg::TOPIC_KEEP);
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic [15:0] idx,
                                     logic [6:0] tl, logic [7:0] pl, logic tr, logic mal);
    mrx_pkg::res_t r;
    r.kind           = kind;
    r.data_byte      = data;
    r.byte_index     = idx;
    r.packet_type    = hdr_byte[7:4];
    r.qos_level      = cur_qos();
    r.packet_id      = ident;
    r.topic_length   = tl;
    r.payload_length = pl;
    r.truncated      = tr;
    r.malformed      = mal;
    r.last           = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void add_packet_end(logic [6:0] tl, logic [7:0] pl, logic mal);
    add_result(mrx_pkg::KIND_END, 8'd0, 16'd0, tl, pl, trunc, mal);
  endfunction

  function automatic void leave_topic(logic done);
    if (cur_qos() != 2'd0) begin
      ph = P_ID_HI;
    end else if (done) begin
      add_packet_end(topic_kept(), 8'd0, 1'b0);
      ph = P_HEADER;
    end else begin
      fcount = '0;
      ph = P_PAYLOAD;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic        done;
    int unsigned need;
    done = 1'b0;
    step_results.delete();
    if (ph != P_HEADER && ph != P_LENGTH) begin
      consumed = consumed + 28'd1;
      done = (consumed >= rem_len);
    end
    case (ph)
      P_HEADER: begin
        hdr_byte  = b;
        rem_len   = '0;
        len_cnt   = '0;
        consumed  = '0;
        topic_tot = '0;
        fcount    = '0;
        ident     = '0;
        trunc     = 1'b0;
        ph        = P_LENGTH;
      end
      P_LENGTH: begin
        rem_len = rem_len | (28'(b[6:0]) << (7 * len_cnt));
        if (b[7]) begin
          if (len_cnt == 2'd3) begin
            add_packet_end(7'd0, 8'd0, 1'b1);
            ph = P_HEADER;
          end else begin
            len_cnt = len_cnt + 2'd1;
          end
        end else if (hdr_byte[7:4] == PKT_PUBLISH) begin
          if (rem_len < 28'd2) begin
            add_packet_end(7'd0, 8'd0, 1'b1);
            if (rem_len == 28'd0) ph = P_HEADER;
            else ph = P_SKIP;
          end else begin
            ph = P_TLEN_HI;
          end
        end else if (rem_len == 28'd0) begin
          ph = P_HEADER;
        end else begin
          ph = P_SKIP;
        end
      end
      P_TLEN_HI: begin
        topic_tot = {b, 8'h00};
        ph = P_TLEN_LO;
      end
      P_TLEN_LO: begin
        topic_tot[7:0] = b;
        need = 2 + topic_tot + ((cur_qos() != 2'd0) ? 2 : 0);
        if (need > rem_len) begin
          add_packet_end(7'd0, 8'd0, 1'b1);
          if (done) ph = P_HEADER;
          else ph = P_SKIP;
        end else if (topic_tot != 16'd0) begin
          fcount = '0;
          ph = P_TOPIC;
        end else begin
          leave_topic(done);
        end
      end
      P_TOPIC: begin
        if (fcount < mrx_pkg::TOPIC_KEEP) begin
          add_result(mrx_pkg::KIND_TOPIC, b, 16'(fcount), 7'd0, 8'd0, 1'b0, 1'b0);
        end else begin
          trunc = 1'b1;
        end
        fcount = fcount + 28'd1;
        if (fcount >= topic_tot) leave_topic(done);
      end
      P_ID_HI: begin
        ident = {b, 8'h00};
        ph = P_ID_LO;
      end
      P_ID_LO: begin
        ident[7:0] = b;
        if (cur_qos() == 2'd1) begin
          add_result(mrx_pkg::KIND_ACK, 8'd0, 16'd0, 7'd0, 8'd0, 1'b0, 1'b0);
        end
        if (done) begin
          add_packet_end(topic_kept(), 8'd0, 1'b0);
          ph = P_HEADER;
        end else begin
          fcount = '0;
          ph = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        if (fcount < mrx_pkg::PAYLOAD_KEEP) begin
          add_result(mrx_pkg::KIND_PAY, b, 16'(fcount), 7'd0, 8'd0, 1'b0, 1'b0);
        end else begin
          trunc = 1'b1;
        end
        fcount = fcount + 28'd1;
        if (done) begin
          add_packet_end(topic_kept(),
                         (fcount < mrx_pkg::PAYLOAD_KEEP) ? 8'(fcount)
                                                          : 8'(mrx_pkg::PAYLOAD_KEEP),
                         1'b0);
          ph = P_HEADER;
        end
      end
      P_SKIP: begin
        if (done) ph = P_HEADER;
      end
      default: ph = P_HEADER;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) results_due.push_back(step_results[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (send_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    counted_items++;
    deframe_byte(b);
  endtask

  task automatic send_packet(input int count);
    int n;
    n = (count < pkt_bytes.size()) ? count : pkt_bytes.size();
    for (int i = 0; i < n; i++) send_byte(pkt_bytes[i]);
  endtask

  // length bytes that keep the remaining body short
  function automatic logic [7:0] tame_length_byte();
    return (len_cnt != 2'd0) ? 8'd0 : 8'($urandom_range(0, 40));
  endfunction

  task automatic finish_packet();
    while (ph != P_HEADER) send_byte((ph == P_LENGTH) ? tame_length_byte() : 8'($urandom));
  endtask

  function automatic void push_length(int unsigned value, int nbytes);
    int minb;
    minb = (value < 128) ? 1 : (value < 16384) ? 2 : (value < 2097152) ? 3 : 4;
    if (nbytes < minb) nbytes = minb;
    for (int i = 0; i < nbytes; i++) pkt_bytes.push_back({i < nbytes - 1, 7'(value >> (7 * i))});
  endfunction

  function automatic void build_publish(logic [1:0] qos, logic [1:0] flags, int tlen, int plen,
                                        int lbytes);
    pkt_bytes.delete();
    pkt_bytes.push_back({PKT_PUBLISH, flags[1], qos, flags[0]});
    push_length(2 + tlen + plen + ((qos != 2'd0) ? 2 : 0), lbytes);
    pkt_bytes.push_back(8'(tlen >> 8));
    pkt_bytes.push_back(8'(tlen));
    repeat (tlen) pkt_bytes.push_back(8'($urandom));
    if (qos != 2'd0) repeat (2) pkt_bytes.push_back(8'($urandom));
    repeat (plen) pkt_bytes.push_back(8'($urandom));
  endfunction

  task automatic test_length_field_limits();
    pkt_bytes = '{8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(pkt_bytes.size());
    pkt_bytes = '{{PKT_PINGRESP, 4'h0}, 8'h00};
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_short_publish();
    pkt_bytes = '{8'h30, 8'h00, 8'h32, 8'h01, 8'hAA};
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_topic_overrun();
    pkt_bytes = '{8'h32, 8'h04, 8'h00, 8'h01, 8'h55, 8'h66};
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_qos_without_payload();
    pkt_bytes = '{8'h36, 8'h04, 8'h00, 8'h00, 8'hFF, 8'hFF,
                  8'h32, 8'h04, 8'h00, 8'h00, 8'hAB, 8'hCD};
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_output_backpressure();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_pending   = 1'b1;
    build_publish(2'd1, 2'b00, 6, 48, 1);
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_random_stream();
    int         pick;
    int         tlen;
    int         plen;
    int         rem;
    int         lbytes;
    logic [1:0] qos;
    logic [3:0] ptype;
    while (counted_items < ITEM_TARGET) begin
      if (counted_items > ITEM_TARGET - 250) begin
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
      end else begin
        send_gaps_on   = ($urandom_range(0, 3) != 0);
        recv_stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick   = $urandom_range(0, 99);
      qos    = 2'($urandom_range(0, 3));
      lbytes = ($urandom_range(0, 6) == 0) ? $urandom_range(2, 4) : 1;
      if (pick < 73) begin
        tlen = ($urandom_range(0, 6) == 0) ? $urandom_range(56, 80) : $urandom_range(0, 12);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 24);
        build_publish(qos, 2'($urandom), tlen, plen, lbytes);
        if (pick < 70) send_packet(pkt_bytes.size());
        else send_packet($urandom_range(1, pkt_bytes.size() - 1));
      end else if (pick < 83) begin
        ptype = 4'($urandom_range(0, 14));
        if (ptype >= PKT_PUBLISH) ptype = ptype + 4'd1;
        rem = $urandom_range(0, 12);
        pkt_bytes.delete();
        pkt_bytes.push_back({ptype, 4'($urandom)});
        push_length(rem, lbytes);
        repeat (rem) pkt_bytes.push_back(8'($urandom));
        send_packet(pkt_bytes.size());
      end else if (pick < 89) begin
        // topic length runs past the remaining length
        rem  = $urandom_range(2, 20);
        tlen = $urandom_range(rem - 1, 65535);
        pkt_bytes.delete();
        pkt_bytes.push_back({PKT_PUBLISH, 1'($urandom), qos, 1'($urandom)});
        push_length(rem, lbytes);
        pkt_bytes.push_back(8'(tlen >> 8));
        pkt_bytes.push_back(8'(tlen));
        send_packet(pkt_bytes.size());
      end else if (pick < 93) begin
        pkt_bytes.delete();
        pkt_bytes.push_back({PKT_PUBLISH, 1'($urandom), qos, 1'($urandom)});
        push_length($urandom_range(0, 1), lbytes);
        send_packet(pkt_bytes.size());
      end else if (pick < 96) begin
        pkt_bytes.delete();
        pkt_bytes.push_back(8'($urandom));
        repeat (4) pkt_bytes.push_back({1'b1, 7'($urandom)});
        send_packet(pkt_bytes.size());
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte((ph == P_LENGTH) ? tame_length_byte() : 8'($urandom));
      end
      finish_packet();
    end
  endtask

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    mrx_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual kind %0d data %0d",
                 $time, out_kind, out_data_byte);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("data_byte", 16'(want.data_byte), 16'(out_data_byte));
        check_field("byte_index", want.byte_index, out_byte_index);
        check_field("packet_type", 16'(want.packet_type), 16'(out_packet_type));
        check_field("qos_level", 16'(want.qos_level), 16'(out_qos_level));
        check_field("packet_id", want.packet_id, out_packet_id);
        check_field("topic_length", 16'(want.topic_length), 16'(out_topic_length));
        check_field("payload_length", 16'(want.payload_length), 16'(out_payload_length));
        check_field("truncated", 16'(want.truncated), 16'(out_truncated));
        check_field("malformed", 16'(want.malformed), 16'(out_malformed));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_pending) begin
      hold_pending = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end else if (recv_stalls_on && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    test_length_field_limits();
    test_short_publish();
    test_topic_overrun();
    test_qos_without_payload();
    test_output_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
